@@ rtl/core/ansi_text_console_assert.svh @@
// ----------------------------------------------------------------------------
// ansi_text_console_assert.svh
// assertion macros shared by the console rtl
// ----------------------------------------------------------------------------
`ifndef ANSI_TEXT_CONSOLE_ASSERT_SVH
`define ANSI_TEXT_CONSOLE_ASSERT_SVH
`ifndef SYNTHESIS
// checked property, off while rst is high
`define ATC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked property, also during reset
`define ATC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ATC_ASSERT(lbl, prop, msg)
`define ATC_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ rtl/core/atc_pkg.sv @@
// ----------------------------------------------------------------------------
// atc_pkg
// shared constants, codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package atc_pkg;

  localparam int COLS       = 80;
  localparam int ROWS       = 25;
  localparam int MAX_PARAMS = 3;
  localparam int CELLS      = ROWS * COLS;
  localparam int ADDR_W     = $clog2(CELLS);
  localparam int ROW_W      = 5;
  localparam int COL_W      = 7;
  localparam int PCNT_W     = 2;
  localparam int CELL_W     = 16;

  localparam logic [7:0] ESC_BYTE   = 8'h1b;
  localparam logic [7:0] BLANK_CHAR = 8'h20;
  localparam logic [7:0] LF_BYTE    = 8'h0a;
  localparam logic [7:0] CR_BYTE    = 8'h0d;
  localparam logic [7:0] LBRACKET   = 8'h5b;
  localparam logic [7:0] SEMI_BYTE  = 8'h3b;
  localparam logic [7:0] DIGIT_LO   = 8'h30;
  localparam logic [7:0] DIGIT_HI   = 8'h39;
  localparam logic [7:0] CMD_SGR    = 8'h6d;
  localparam logic [7:0] CMD_CUP_H  = 8'h48;
  localparam logic [7:0] CMD_CUP_F  = 8'h66;
  localparam logic [7:0] CMD_ED     = 8'h4a;
  localparam logic [7:0] CMD_EL     = 8'h4b;

  localparam logic [7:0]  RESET_ATTR = 8'h07;
  localparam logic [3:0]  RESET_FORE = 4'h7;
  localparam logic [3:0]  RESET_BACK = 4'h0;
  localparam logic [15:0] SGR_FG_LO  = 16'd30;
  localparam logic [15:0] SGR_FG_HI  = 16'd37;
  localparam logic [15:0] SGR_BG_LO  = 16'd40;
  localparam logic [15:0] SGR_BG_HI  = 16'd47;
  localparam logic [15:0] ACC_MAX    = 16'hffff;

  typedef enum logic [1:0] {
    FUNC_ANSI = 2'd0,
    FUNC_RAW  = 2'd1,
    FUNC_BS   = 2'd2,
    FUNC_READ = 2'd3
  } func_t;

  // ansi colour order to vga colour order
  function automatic logic [3:0] colour_map(input logic [2:0] c);
    logic [3:0] v;
    unique case (c)
      3'd0:    v = 4'd0;
      3'd1:    v = 4'd4;
      3'd2:    v = 4'd2;
      3'd3:    v = 4'd6;
      3'd4:    v = 4'd1;
      3'd5:    v = 4'd5;
      3'd6:    v = 4'd3;
      default: v = 4'd7;
    endcase
    return v;
  endfunction

  typedef struct packed {
    logic take;        // capture input transfer
    logic exec;        // run one decode/update step
    logic copy_step;   // scroll: read one cell a row below
    logic drain;       // scroll: last copy write, arm bottom row blank
    logic fill_step;   // blank one cell
    logic capture_rd;  // latch read data
    logic load_out;    // load result register
  } atc_cmd_t;

  typedef struct packed {
    logic need_scroll;
    logic need_fill;
    logic need_read;
    logic redo;
    logic scan_done;
    logic fill_done;
    logic out_free;
  } atc_stat_t;

endpackage

@@ rtl/core/ansi_text_console.sv @@
// ----------------------------------------------------------------------------
// ansi_text_console
// text console cell store with cursor, colours and an ansi escape subset
// ----------------------------------------------------------------------------
//  channel | dir | tdata fields (low bit up)                              | tuser/tlast
//  s_axis  | in  | func[1:0] data_byte[9:2] read_row[14:10] read_col[21:15] | none
//  m_axis  | out | cell_char cell_attr cur_row cur_col cur_attr           | none
//
//  an item passes through accept, decode and result load; a read adds a capture step for the
//  registered cell store port, a lone escape adds one decode step
//  scroll copies each row up at one cell per cycle, then blanks the bottom row
//  erase display blanks all ROWS*COLS cells, erase line the cells from the cursor column on
//  after reset all ROWS*COLS cells (2000) of the store are blanked before s_tready rises
//  one result waits in the output register while the next item is decoded
// ----------------------------------------------------------------------------
module ansi_text_console
  import atc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // func, data_byte, read_row, read_col, zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // cell_char, cell_attr, cur_row, cur_col, cur_attr, pad
);

  atc_cmd_t  cmd;
  atc_stat_t stat;

  // controller: sequences each transfer through decode, sweeps and handoff
  atc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: parser state, cursor, cell store and the result register
  atc_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (s_tdata),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_data  (m_tdata)
  );

endmodule

@@ rtl/core/atc_ram.sv @@
// ----------------------------------------------------------------------------
// atc_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module atc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/atc_datapath.sv @@
// ----------------------------------------------------------------------------
// atc_datapath
// cursor, attribute, escape parser registers, cell store and result register
// ----------------------------------------------------------------------------
`include "ansi_text_console_assert.svh"

module atc_datapath
  import atc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  atc_cmd_t          cmd,
  output atc_stat_t         stat,
  input  logic [23:0]       in_data,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [39:0]       out_data
);

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ESC    = 2'd1,
    MODE_CSI    = 2'd2
  } mode_t;

  localparam logic [ADDR_W-1:0] SCAN_LAST = ADDR_W'((ROWS - 1) * COLS - 1);
  localparam logic [ADDR_W-1:0] LAST_ROW  = ADDR_W'((ROWS - 1) * COLS);
  localparam logic [ADDR_W-1:0] CELL_LAST = ADDR_W'(CELLS - 1);

  func_t             it_func;
  logic [7:0]        it_byte;
  logic [ROW_W-1:0]  it_rr;
  logic [COL_W-1:0]  it_rc;

  logic [ROW_W-1:0]  cur_row, row_next;
  logic [COL_W-1:0]  cur_col, col_next;
  logic [7:0]        attr, attr_next;
  logic [3:0]        fore, fore_next, back, back_next;
  mode_t             mode, mode_next;
  logic [15:0]       acc, acc_next;
  logic              has_digit, has_digit_next;
  logic [PCNT_W-1:0] pcnt, pcnt_p;
  logic [15:0]       pst [MAX_PARAMS];
  logic [15:0]       pst_p [MAX_PARAMS];
  logic              clr_params;

  logic [ADDR_W-1:0] fill_addr, fill_last, scan, copy_addr;
  logic              copy_pend;
  logic [7:0]        cell_char, cell_attr;

  logic              ex_we, do_put, row_adv, is_push;
  logic [7:0]        put_val;
  logic [ADDR_W-1:0] ex_addr, fill_start, fill_end, cur_addr, rd_addr;
  logic              need_scroll, need_fill, need_read, redo;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;

  assign cur_addr = ADDR_W'(int'(cur_row) * COLS + int'(cur_col));
  assign rd_addr  = ADDR_W'(int'(it_rr) * COLS + int'(it_rc));

  always_comb begin
    logic [19:0] acc_ext;
    logic [15:0] v, r16, c16;
    row_next       = cur_row;
    col_next       = cur_col;
    attr_next      = attr;
    fore_next      = fore;
    back_next      = back;
    mode_next      = mode;
    acc_next       = acc;
    has_digit_next = has_digit;
    clr_params     = 1'b0;
    is_push        = 1'b0;
    ex_we          = 1'b0;
    ex_addr        = cur_addr;
    do_put         = 1'b0;
    put_val        = it_byte;
    row_adv        = 1'b0;
    need_scroll    = 1'b0;
    need_fill      = 1'b0;
    need_read      = 1'b0;
    redo           = 1'b0;
    fill_start     = '0;
    fill_end       = CELL_LAST;
    acc_ext        = '0;
    v              = '0;
    r16            = '0;
    c16            = '0;

    // parameter store after pushing a pending parameter
    pcnt_p = pcnt;
    for (int i = 0; i < MAX_PARAMS; i++) begin
      pst_p[i] = pst[i];
    end
    if (has_digit && (int'(pcnt) < MAX_PARAMS)) begin
      for (int i = 0; i < MAX_PARAMS; i++) begin
        if (int'(pcnt) == i) begin
          pst_p[i] = acc;
        end
      end
      pcnt_p = pcnt + PCNT_W'(1);
    end

    case (it_func)
      FUNC_ANSI: begin
        if (mode == MODE_ESC) begin
          if (it_byte == LBRACKET) begin
            mode_next      = MODE_CSI;
            acc_next       = '0;
            has_digit_next = 1'b0;
            clr_params     = 1'b1;
          end else begin
            // lone escape prints, then the byte is decoded again
            mode_next = MODE_NORMAL;
            do_put    = 1'b1;
            put_val   = ESC_BYTE;
            redo      = 1'b1;
          end
        end else if (mode == MODE_CSI) begin
          if (it_byte >= DIGIT_LO && it_byte <= DIGIT_HI) begin
            acc_ext = {acc, 3'b000} + {2'b00, acc, 1'b0} + 20'(it_byte - DIGIT_LO);
            acc_next       = (acc_ext > 20'(ACC_MAX)) ? ACC_MAX : acc_ext[15:0];
            has_digit_next = 1'b1;
          end else begin
            is_push        = 1'b1;
            acc_next       = '0;
            has_digit_next = 1'b0;
            if (it_byte != SEMI_BYTE) begin
              mode_next = MODE_NORMAL;
              case (it_byte)
                CMD_SGR: begin
                  if (pcnt_p == '0 || pst_p[0] == '0) begin
                    fore_next = RESET_FORE;
                    back_next = RESET_BACK;
                  end
                  for (int i = 0; i < MAX_PARAMS; i++) begin
                    v = pst_p[i];
                    if (i < int'(pcnt_p)) begin
                      if (v >= SGR_FG_LO && v <= SGR_FG_HI) begin
                        fore_next = colour_map(3'(v - SGR_FG_LO));
                      end else if (v >= SGR_BG_LO && v <= SGR_BG_HI) begin
                        back_next = colour_map(3'(v - SGR_BG_LO));
                      end
                    end
                  end
                  attr_next = {back_next, fore_next};
                end
                CMD_CUP_H, CMD_CUP_F: begin
                  r16 = (pst_p[0] != '0) ? pst_p[0] - 16'd1 : '0;
                  c16 = (pst_p[1] != '0) ? pst_p[1] - 16'd1 : '0;
                  if (r16 < 16'(ROWS)) begin
                    row_next = ROW_W'(r16);
                  end
                  if (c16 < 16'(COLS)) begin
                    col_next = COL_W'(c16);
                  end
                end
                CMD_ED: begin
                  need_fill  = 1'b1;
                  fill_start = '0;
                  fill_end   = CELL_LAST;
                  row_next   = '0;
                  col_next   = '0;
                end
                CMD_EL: begin
                  need_fill  = 1'b1;
                  fill_start = cur_addr;
                  fill_end   = ADDR_W'(int'(cur_row) * COLS + (COLS - 1));
                end
                default: ;
              endcase
            end
          end
        end else if (it_byte == ESC_BYTE) begin
          mode_next = MODE_ESC;
        end else begin
          do_put = 1'b1;
        end
      end
      FUNC_RAW: do_put = 1'b1;
      FUNC_BS: begin
        if (cur_col != '0) begin
          col_next = cur_col - COL_W'(1);
          ex_we    = 1'b1;
          ex_addr  = cur_addr - ADDR_W'(1);
        end else if (cur_row != '0) begin
          row_next = cur_row - ROW_W'(1);
          col_next = COL_W'(COLS - 1);
          ex_we    = 1'b1;
          ex_addr  = cur_addr - ADDR_W'(1);
        end
      end
      default: begin
        need_read = (int'(it_rr) < ROWS) && (int'(it_rc) < COLS);
      end
    endcase

    if (do_put) begin
      if (put_val == LF_BYTE) begin
        col_next = '0;
        row_adv  = 1'b1;
      end else if (put_val == CR_BYTE) begin
        col_next = '0;
      end else begin
        ex_we   = 1'b1;
        ex_addr = cur_addr;
        if (int'(cur_col) == COLS - 1) begin
          col_next = '0;
          row_adv  = 1'b1;
        end else begin
          col_next = cur_col + COL_W'(1);
        end
      end
      if (row_adv) begin
        if (int'(cur_row) == ROWS - 1) begin
          need_scroll = 1'b1;
        end else begin
          row_next = cur_row + ROW_W'(1);
        end
      end
    end
  end

  assign stat.need_scroll = need_scroll;
  assign stat.need_fill   = need_fill;
  assign stat.need_read   = need_read;
  assign stat.redo        = redo;
  assign stat.scan_done   = (scan == SCAN_LAST);
  assign stat.fill_done   = (fill_addr == fill_last);
  assign stat.out_free    = !out_valid || out_ready;

  // write port: scroll copy, then blanking, then the step's own write
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ex_addr;
    ram_wdata = {attr, (it_func == FUNC_BS) ? BLANK_CHAR : put_val};
    if (copy_pend) begin
      ram_we    = 1'b1;
      ram_waddr = copy_addr;
      ram_wdata = ram_rdata;
    end else if (cmd.fill_step) begin
      ram_we    = 1'b1;
      ram_waddr = fill_addr;
      ram_wdata = {attr, BLANK_CHAR};
    end else if (cmd.exec && ex_we) begin
      ram_we = 1'b1;
    end
  end

  assign ram_raddr = cmd.copy_step ? scan + ADDR_W'(COLS) : rd_addr;

  atc_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row   <= '0;
      cur_col   <= '0;
      attr      <= RESET_ATTR;
      fore      <= RESET_FORE;
      back      <= RESET_BACK;
      mode      <= MODE_NORMAL;
      acc       <= '0;
      has_digit <= 1'b0;
      pcnt      <= '0;
      for (int i = 0; i < MAX_PARAMS; i++) begin
        pst[i] <= '0;
      end
      fill_addr <= '0;
      fill_last <= CELL_LAST;
      scan      <= '0;
      copy_pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      copy_pend <= cmd.copy_step;
      if (cmd.copy_step) begin
        copy_addr <= scan;
        scan      <= scan + ADDR_W'(1);
      end
      if (cmd.take) begin
        it_func <= func_t'(in_data[1:0]);
        it_byte <= in_data[9:2];
        it_rr   <= in_data[14:10];
        it_rc   <= in_data[21:15];
      end
      if (cmd.exec) begin
        cur_row   <= row_next;
        cur_col   <= col_next;
        attr      <= attr_next;
        fore      <= fore_next;
        back      <= back_next;
        mode      <= mode_next;
        acc       <= acc_next;
        has_digit <= has_digit_next;
        cell_char <= '0;
        cell_attr <= '0;
        if (clr_params) begin
          pcnt <= '0;
          for (int i = 0; i < MAX_PARAMS; i++) begin
            pst[i] <= '0;
          end
        end else if (is_push) begin
          pcnt <= pcnt_p;
          for (int i = 0; i < MAX_PARAMS; i++) begin
            pst[i] <= pst_p[i];
          end
        end
        if (need_scroll) begin
          scan <= '0;
        end
        if (need_fill) begin
          fill_addr <= fill_start;
          fill_last <= fill_end;
        end
      end
      if (cmd.drain) begin
        fill_addr <= LAST_ROW;
        fill_last <= CELL_LAST;
      end
      if (cmd.fill_step && !stat.fill_done) begin
        fill_addr <= fill_addr + ADDR_W'(1);
      end
      if (cmd.capture_rd) begin
        cell_char <= ram_rdata[7:0];
        cell_attr <= ram_rdata[15:8];
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data <= {4'b0, attr, cur_col, cur_row, cell_attr, cell_char};
    end
  end

  `ATC_ASSERT(a_row_range, int'(cur_row) < ROWS, "cursor row out of range")
  `ATC_ASSERT(a_col_range, int'(cur_col) < COLS, "cursor column out of range")
  `ATC_ASSERT(a_fill_order, cmd.fill_step |-> fill_addr <= fill_last, "blank sweep overran")
  `ATC_ASSERT(a_copy_alone, copy_pend |-> !cmd.fill_step && !cmd.exec,
              "scroll copy write collides with another write")

endmodule

@@ rtl/core/atc_ctrl.sv @@
// ----------------------------------------------------------------------------
// atc_ctrl
// sequencer for decode steps, scroll copy, blanking sweeps and result handoff
// ----------------------------------------------------------------------------
`include "ansi_text_console_assert.svh"

module atc_ctrl
  import atc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  atc_stat_t stat,
  output atc_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_SCROLL,
    S_DRAIN,
    S_FILL,
    S_READ,
    S_DONE
  } state_t;

  state_t state;
  logic   redo;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd            = '0;
    cmd.take       = (state == S_IDLE) && in_valid;
    cmd.exec       = (state == S_EXEC);
    cmd.copy_step  = (state == S_SCROLL);
    cmd.drain      = (state == S_DRAIN);
    cmd.fill_step  = (state == S_FILL) || (state == S_CLEAR);
    cmd.capture_rd = (state == S_READ);
    cmd.load_out   = (state == S_DONE) && stat.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      redo  <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          if (stat.fill_done) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) state <= S_EXEC;
        end
        S_EXEC: begin
          redo <= stat.redo;
          if (stat.need_scroll)    state <= S_SCROLL;
          else if (stat.need_fill) state <= S_FILL;
          else if (stat.need_read) state <= S_READ;
          else if (stat.redo)      state <= S_EXEC;
          else                     state <= S_DONE;
        end
        S_SCROLL: begin
          if (stat.scan_done) state <= S_DRAIN;
        end
        S_DRAIN: state <= S_FILL;
        S_FILL: begin
          if (stat.fill_done) state <= redo ? S_EXEC : S_DONE;
        end
        S_READ: state <= S_DONE;
        S_DONE: begin
          if (stat.out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ATC_ASSERT(a_one_cmd, $onehot0({cmd.exec, cmd.copy_step, cmd.fill_step, cmd.capture_rd}),
              "controller issued two datapath steps at once")
  `ATC_ASSERT(a_exec_after, cmd.take |=> cmd.exec, "accepted item not decoded next cycle")
  `ATC_ASSERT(a_drain_fill, cmd.drain |=> cmd.fill_step, "scroll not followed by row blank")

endmodule

@@ verif/ansi_text_console_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ansi_text_console_tb
// drives escape sequences, raw text, backspaces and cell reads into the console,
// predicts the cell store, cursor and colour state alongside it and checks
// every result transfer against that prediction
// ----------------------------------------------------------------------------
module ansi_text_console_tb;
  import atc_pkg::*;

  // packed from the top bit down, so cell_char lands in the low bits
  typedef struct packed {
    logic [7:0] attr;
    logic [6:0] col;
    logic [4:0] row;
    logic [7:0] at;
    logic [7:0] ch;
  } console_view_t;

  // shadow console: holds its own copy of the screen and parser state
  class console_scoreboard;
    logic [15:0]   cells[CELLS];
    int unsigned   crow, ccol;
    logic [7:0]    attr;
    logic [3:0]    fore, back;
    int            mode;
    int unsigned   acc;
    bit            has_digit;
    int unsigned   pcount;
    int unsigned   pstore[MAX_PARAMS];
    console_view_t pending[$];
    int            errors;
    int            checked;

    function void clear_all();
      attr = RESET_ATTR;
      foreach (cells[i]) cells[i] = 16'h0720;
      crow = 0; ccol = 0; fore = RESET_FORE; back = RESET_BACK;
      mode = 0; acc = 0; has_digit = 0; pcount = 0;
      foreach (pstore[i]) pstore[i] = 0;
      errors = 0; checked = 0;
    endfunction

    function logic [15:0] blank();
      return {attr, BLANK_CHAR};
    endfunction

    function void wrap_scroll();
      if (ccol >= COLS) begin
        ccol = 0;
        crow++;
      end
      if (crow >= ROWS) begin
        for (int i = 0; i < (ROWS - 1) * COLS; i++) cells[i] = cells[i + COLS];
        for (int i = 0; i < COLS; i++) cells[(ROWS - 1) * COLS + i] = blank();
        crow = ROWS - 1;
      end
    endfunction

    function void put(logic [7:0] b);
      if (b == LF_BYTE) begin
        ccol = 0;
        crow++;
      end else if (b == CR_BYTE) begin
        ccol = 0;
      end else begin
        cells[crow * COLS + ccol] = {attr, b};
        ccol++;
      end
      wrap_scroll();
    endfunction

    function void push_param();
      if (has_digit && pcount < MAX_PARAMS) begin
        pstore[pcount] = acc;
        pcount++;
      end
      acc = 0;
      has_digit = 0;
    endfunction

    function logic [3:0] vga_colour(int unsigned v);
      logic [3:0] m[8];
      m = '{4'd0, 4'd4, 4'd2, 4'd6, 4'd1, 4'd5, 4'd3, 4'd7};
      return m[v & 7];
    endfunction

    function void run_cmd(logic [7:0] b);
      int unsigned r, c;
      if (b == CMD_SGR) begin
        if (pcount == 0 || pstore[0] == 0) begin
          fore = RESET_FORE;
          back = RESET_BACK;
        end
        for (int i = 0; i < pcount; i++) begin
          if (pstore[i] >= SGR_FG_LO && pstore[i] <= SGR_FG_HI) fore = vga_colour(pstore[i] - 30);
          else if (pstore[i] >= SGR_BG_LO && pstore[i] <= SGR_BG_HI)
            back = vga_colour(pstore[i] - 40);
        end
        attr = {back, fore};
      end else if (b == CMD_CUP_H || b == CMD_CUP_F) begin
        r = pstore[0] ? pstore[0] - 1 : 0;
        c = pstore[1] ? pstore[1] - 1 : 0;
        if (r < ROWS) crow = r;
        if (c < COLS) ccol = c;
      end else if (b == CMD_ED) begin
        foreach (cells[i]) cells[i] = blank();
        crow = 0; ccol = 0;
      end else if (b == CMD_EL) begin
        for (int k = ccol; k < COLS; k++) cells[crow * COLS + k] = blank();
      end
    endfunction

    function void ansi(logic [7:0] b);
      if (mode == 1) begin
        if (b == LBRACKET) begin
          mode = 2; acc = 0; has_digit = 0; pcount = 0;
          foreach (pstore[i]) pstore[i] = 0;
          return;
        end
        mode = 0;
        put(ESC_BYTE);
      end
      if (mode == 2) begin
        if (b >= DIGIT_LO && b <= DIGIT_HI) begin
          acc = acc * 10 + (b - DIGIT_LO);
          if (acc > ACC_MAX) acc = ACC_MAX;
          has_digit = 1;
        end else if (b == SEMI_BYTE) begin
          push_param();
        end else begin
          push_param();
          mode = 0;
          run_cmd(b);
        end
        return;
      end
      if (b == ESC_BYTE) mode = 1;
      else put(b);
    endfunction

    // note an accepted input transfer and queue the expected result
    function void note_input(func_t f, logic [7:0] d, logic [4:0] rr, logic [6:0] rc);
      console_view_t v;
      v = '0;
      case (f)
        FUNC_ANSI: ansi(d);
        FUNC_RAW:  put(d);
        FUNC_BS: begin
          if (ccol > 0 || crow > 0) begin
            if (ccol > 0) ccol--;
            else begin
              crow--;
              ccol = COLS - 1;
            end
            cells[crow * COLS + ccol] = blank();
          end
        end
        default: begin
          if (rr < ROWS && rc < COLS) {v.at, v.ch} = cells[rr * COLS + rc];
        end
      endcase
      v.row = crow[4:0];
      v.col = ccol[6:0];
      v.attr = attr;
      pending.push_back(v);
    endfunction

    function void check_result(console_view_t got);
      console_view_t exp;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result transfer %h", got);
        return;
      end
      exp = pending.pop_front();
      checked++;
      if (got !== exp) begin
        errors++;
        if (errors <= 10)
          $display({"mismatch #%0d: exp ch=%h at=%h row=%0d col=%0d attr=%h, ",
                    "got ch=%h at=%h row=%0d col=%0d attr=%h"},
                   checked, exp.ch, exp.at, exp.row, exp.col, exp.attr,
                   got.ch, got.at, got.row, got.col, got.attr);
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // func, data_byte, read_row, read_col, zero pad
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [39:0] m_tdata;        // cell_char, cell_attr, cur_row, cur_col, cur_attr, pad

  console_scoreboard sb;
  int  idle_cycles;
  int  n_sent;
  bit  timed_out;
  bit  rx_quiet;     // receiver always ready during the quiet stretches

  localparam int WATCHDOG = 20000;

  always #2 clk = ~clk;

  ansi_text_console dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // watchdog: cycles with no transfer on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  always @(posedge clk) begin
    if (!rst && idle_cycles > WATCHDOG && !timed_out) begin
      timed_out = 1;
      $display("watchdog expired with %0d results outstanding", sb.pending.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // result side: sample at the rising edge, random stall drawn per transfer
  initial begin
    int gap;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = rx_quiet ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
        m_tready <= 0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      sb.check_result(m_tdata[35:0]);
      @(negedge clk);
    end
  end

  // one input transfer after a random gap; the prediction is taken on accept
  task automatic send_item(func_t f, logic [7:0] d, logic [4:0] rr = 5'd0,
                           logic [6:0] rc = 7'd0);
    int gap;
    gap = rx_quiet ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1;
    s_tdata  <= {2'b00, rc, rr, d, f};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_input(f, d, rr, rc);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(string s, func_t f = FUNC_ANSI);
    foreach (s[i]) send_item(f, s[i]);
  endtask

  task automatic send_read();
    send_item(FUNC_READ, 8'h00, 5'($urandom_range(0, 31)), 7'($urandom_range(0, 127)));
  endtask

  // a well-formed escape sequence with random parameters
  task automatic send_escape();
    int np;
    logic [7:0] term[6];
    term = '{CMD_SGR, CMD_SGR, CMD_CUP_H, CMD_CUP_F, CMD_EL, CMD_ED};
    np = $urandom_range(0, 3);
    send_item(FUNC_ANSI, ESC_BYTE);
    send_item(FUNC_ANSI, LBRACKET);
    for (int i = 0; i < np; i++) begin
      case ($urandom_range(0, 3))
        0: send_text($sformatf("%0d", $urandom_range(30, 47)));
        1: send_text($sformatf("%0d", $urandom_range(0, 30)));
        2: send_text($sformatf("%0d", $urandom_range(0, 90)));
        default: ;  // empty parameter
      endcase
      if (i < np - 1) send_item(FUNC_ANSI, SEMI_BYTE);
    end
    // erase display is slow, keep it rare
    send_item(FUNC_ANSI, term[$urandom_range(0, ($urandom_range(0, 9) == 0) ? 5 : 4)]);
  endtask

  // drop valid and wait for every expected result
  task automatic wait_drain();
    s_tvalid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  initial begin
    sb = new();
    sb.clear_all();
    idle_cycles = 0;
    n_sent = 0;
    timed_out = 0;
    rx_quiet = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: reads at the corners and out of range
    send_item(FUNC_READ, 8'h00, 0, 0);
    send_item(FUNC_READ, 8'hff, 24, 79);
    send_item(FUNC_READ, 8'h00, 31, 127);
    send_item(FUNC_BS, 8'h00);                 // backspace at home
    send_item(FUNC_RAW, 8'hff);                // high byte stays 8 bits
    send_item(FUNC_RAW, 8'h00);
    send_item(FUNC_RAW, CR_BYTE);
    send_item(FUNC_RAW, LF_BYTE);
    send_text("\033[31;44m");                  // colours
    send_text("\033[;;m");                     // empty parameters, reset
    send_text("\033[99999999H");               // saturated accumulator: row ignored, column to 0
    send_text("\033[25;80f");                  // bottom-right corner
    send_item(FUNC_RAW, 8'h41);                // wrap plus scroll
    send_item(FUNC_BS, 8'h00);                 // back onto previous row
    send_text("\033x");                        // lone escape printed
    send_text("\033\033[K");                   // escape then new escape, erase line
    send_text("\033[5z");                      // unknown terminator
    send_text("\033[2J");
    send_item(FUNC_READ, 8'h00, 0, 0);
    send_item(FUNC_ANSI, ESC_BYTE);            // pending escape across other funcs
    send_item(FUNC_RAW, 8'h42);
    send_item(FUNC_ANSI, 8'h43);

    // hold off until everything has come back, with no stalls
    wait_drain();
    rx_quiet = 1;
    send_text("abc\033[1;1H");
    wait_drain();
    rx_quiet = 0;

    // random part: mostly escapes and text, with noise and broken sequences
    while (n_sent < 1250) begin
      case ($urandom_range(0, 9))
        0, 1:    send_escape();
        2, 3:    send_item(FUNC_RAW, 8'($urandom_range(0, 255)));
        4:       send_item(FUNC_ANSI, 8'($urandom_range(0, 255)));
        5:       send_item(FUNC_BS, 8'($urandom_range(0, 255)));
        6, 7:    send_read();
        8:       send_item($urandom_range(0, 1) ? FUNC_RAW : FUNC_ANSI,
                           $urandom_range(0, 3) ? LF_BYTE : CR_BYTE);
        default: begin
          send_item(FUNC_ANSI, ESC_BYTE);       // broken sequence
          if ($urandom_range(0, 1)) send_item(FUNC_ANSI, LBRACKET);
          send_item(FUNC_ANSI, 8'($urandom_range(0, 255)));
        end
      endcase
    end

    wait_drain();
    repeat (50) @(negedge clk);
    $display("sent %0d items (escapes, raw text, backspaces, reads), checked %0d results",
             n_sent, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
